FILE: hdl/skset_pkg.sv
package skset_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int DEF_KEY_BITS = 16;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 16;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PROBE,
        S_DECIDE,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
    } skset_req_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } skset_rsp_t;

endpackage

FILE: hdl/skset_ram.sv
module skset_ram #(
    parameter int DEPTH = skset_pkg::DEF_CAPACITY,
    parameter int WIDTH = skset_pkg::DEF_KEY_BITS
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/sorted_key_set_top.sv
// Each binary-search probe reads the key store in the search state and compares the word in
// the probe state, at most clog2(CAPACITY+1) probes; a hit goes straight to the decide state,
// an absent key ends the search with one more pass through the search state. An insert or
// delete that changes the set then moves entries in the shift state, and the result is posted
// in the response state. Throughput: one word at a time, set by the single key store port pair.
// Reset: asynchronous, active low; the set is empty after reset and the store is not cleared.
module sorted_key_set_top #(
    parameter int CAPACITY = skset_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = skset_pkg::DEF_KEY_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  skset_pkg::skset_req_t req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output skset_pkg::skset_rsp_t rsp
);

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int POS_W   = skset_pkg::POS_W;
    localparam int COUNT_W = skset_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    skset_pkg::state_t state_reg, state_next;

    logic [skset_pkg::OP_W-1:0] op_reg, op_next;
    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           lo_reg, lo_next;
    logic [CNT_W-1:0]           hi_reg, hi_next;
    logic [CNT_W-1:0]           mid_reg, mid_next;
    logic [CNT_W-1:0]           where_reg, where_next;
    logic [CNT_W-1:0]           moves_reg, moves_next;
    logic [ADDR_W-1:0]          src_reg, src_next;
    logic [ADDR_W-1:0]          dst_reg, dst_next;
    logic                       found_reg, found_next;
    logic                       pend_reg, pend_next;
    logic                       up_reg, up_next;
    skset_pkg::status_t         status_reg, status_next;
    skset_pkg::skset_rsp_t      rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [KEY_BITS-1:0] mem_wr_data;
    logic                mem_rd_en;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [KEY_BITS-1:0] mem_rd_data;

    logic [CNT_W-1:0] mid_calc;
    logic             search_more;
    logic             rsp_slot_free;
    logic             is_full;
    logic             shift_done;

    skset_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign mid_calc      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign search_more   = lo_reg < hi_reg;
    assign rsp_slot_free = !rsp_valid_reg || rsp_ready;
    assign is_full       = count_reg == CAP_CNT;
    assign shift_done    = (moves_reg == '0) && !pend_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skset_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = skset_pkg::S_SEARCH;
                end
            end
            skset_pkg::S_SEARCH:
            begin
                state_next = search_more ? skset_pkg::S_PROBE : skset_pkg::S_DECIDE;
            end
            skset_pkg::S_PROBE:
            begin
                state_next = (key_reg == mem_rd_data) ? skset_pkg::S_DECIDE
                                                      : skset_pkg::S_SEARCH;
            end
            skset_pkg::S_DECIDE:
            begin
                state_next = skset_pkg::S_RESP;
                if ((op_reg == skset_pkg::OP_INSERT && !found_reg && !is_full) ||
                    (op_reg == skset_pkg::OP_DELETE && found_reg))
                begin
                    state_next = skset_pkg::S_SHIFT;
                end
            end
            skset_pkg::S_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = skset_pkg::S_RESP;
                end
            end
            skset_pkg::S_RESP:
            begin
                if (rsp_slot_free)
                begin
                    state_next = skset_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skset_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and store control.
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        where_next     = where_reg;
        moves_next     = moves_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        found_next     = found_reg;
        pend_next      = 1'b0;
        up_next        = up_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = dst_reg;
        mem_wr_data    = mem_rd_data;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = mid_calc[ADDR_W-1:0];

        unique case (state_reg)
            skset_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    key_next   = KEY_BITS'(req.key);
                    lo_next    = '0;
                    hi_next    = count_reg;
                    found_next = 1'b0;
                end
            end
            skset_pkg::S_SEARCH:
            begin
                mid_next = mid_calc;
                if (search_more)
                begin
                    mem_rd_en = 1'b1;
                end
                else
                begin
                    where_next = lo_reg;
                end
            end
            skset_pkg::S_PROBE:
            begin
                if (key_reg < mem_rd_data)
                begin
                    hi_next = mid_reg;
                end
                else if (key_reg > mem_rd_data)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    found_next = 1'b1;
                    where_next = mid_reg;
                end
            end
            skset_pkg::S_DECIDE:
            begin
                case (op_reg)
                    skset_pkg::OP_INSERT:
                    begin
                        if (found_reg)
                        begin
                            status_next = skset_pkg::ST_PRESENT;
                        end
                        else if (is_full)
                        begin
                            status_next = skset_pkg::ST_FULL;
                            where_next  = '0;
                        end
                        else
                        begin
                            // Move entries where..count-1 up one place, top first.
                            status_next = skset_pkg::ST_DONE;
                            moves_next  = count_reg - where_reg;
                            src_next    = ADDR_W'(count_reg - 1'b1);
                            up_next     = 1'b1;
                        end
                    end
                    skset_pkg::OP_DELETE:
                    begin
                        if (found_reg)
                        begin
                            // Move entries where+1..count-1 down one place, bottom first.
                            status_next = skset_pkg::ST_DONE;
                            moves_next  = count_reg - where_reg - 1'b1;
                            src_next    = ADDR_W'(where_reg + 1'b1);
                            up_next     = 1'b0;
                        end
                        else
                        begin
                            status_next = skset_pkg::ST_ABSENT;
                            where_next  = '0;
                        end
                    end
                    default:
                    begin
                        if (found_reg)
                        begin
                            status_next = skset_pkg::ST_DONE;
                        end
                        else
                        begin
                            status_next = skset_pkg::ST_ABSENT;
                            where_next  = '0;
                        end
                    end
                endcase
            end
            skset_pkg::S_SHIFT:
            begin
                // Reads and writes overlap: the word read in one cycle is written back
                // one place over in the next.
                if (moves_reg != '0)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = src_reg;
                    moves_next  = moves_reg - 1'b1;
                    pend_next   = 1'b1;
                    src_next    = up_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    dst_next    = up_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                end
                if (pend_reg)
                begin
                    mem_wr_en = 1'b1;
                end
                else if (moves_reg == '0)
                begin
                    if (up_reg)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = ADDR_W'(where_reg);
                        mem_wr_data = key_reg;
                        count_next  = count_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            skset_pkg::S_RESP:
            begin
                if (rsp_slot_free)
                begin
                    rsp_next.status   = status_reg;
                    rsp_next.position = POS_W'(where_reg);
                    rsp_next.count    = COUNT_W'(count_reg);
                    rsp_valid_next    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skset_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        where_reg  <= where_next;
        moves_reg  <= moves_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        found_reg  <= found_next;
        up_reg     <= up_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign req_ready = (state_reg == skset_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count exceeds capacity");

    a_search_window : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == skset_pkg::S_PROBE) |-> (lo_reg <= mid_reg) && (mid_reg < hi_reg)
                                              && (hi_reg <= count_reg))
        else $error("binary search probe outside its window");

    // The next word may already be working on the set while this result waits, so the
    // result's own count is checked rather than the live one.
    a_full_refusal : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == skset_pkg::ST_FULL) |->
            (rsp.position == '0) && (rsp.count == COUNT_W'(CAPACITY)))
        else $error("refused insert while the store is not full");

endmodule

FILE: verif/sorted_key_set_checker.sv
module sorted_key_set_checker #(
    parameter int CAPACITY = skset_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = skset_pkg::DEF_KEY_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  skset_pkg::skset_req_t req,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  skset_pkg::skset_rsp_t rsp,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W   = skset_pkg::KEY_W;
    localparam int POS_W   = skset_pkg::POS_W;
    localparam int COUNT_W = skset_pkg::COUNT_W;

    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}}
                            : KEY_W'((64'd1 << KEY_BITS) - 64'd1);

    logic [KEY_W-1:0]      shadow_keys [CAPACITY];
    int                    shadow_count;
    skset_pkg::skset_rsp_t expected_answers [$];

    // Applies one request to the shadow set and returns the answer it must give.
    function skset_pkg::skset_rsp_t apply_request(skset_pkg::skset_req_t r);
        logic [KEY_W-1:0]      k;
        int                    lo;
        int                    hi;
        int                    mid;
        int                    slot;
        int                    i;
        bit                    hit;
        skset_pkg::skset_rsp_t ans;
        k = r.key & KEY_MASK;
        lo = 0;
        hi = shadow_count;
        hit = 1'b0;
        slot = 0;
        while (lo < hi && !hit)
        begin
            mid = lo + (hi - lo) / 2;
            if (k < shadow_keys[mid])
                hi = mid;
            else if (k > shadow_keys[mid])
                lo = mid + 1;
            else
            begin
                hit = 1'b1;
                slot = mid;
            end
        end
        if (!hit)
            slot = lo;
        ans.position = '0;
        if (r.operation == skset_pkg::OP_INSERT)
        begin
            // A present key wins over a full store.
            if (hit)
            begin
                ans.status = skset_pkg::ST_PRESENT;
                ans.position = POS_W'(slot);
            end
            else if (shadow_count >= CAPACITY)
                ans.status = skset_pkg::ST_FULL;
            else
            begin
                for (i = shadow_count; i > slot; i--)
                    shadow_keys[i] = shadow_keys[i-1];
                shadow_keys[slot] = k;
                shadow_count++;
                ans.status = skset_pkg::ST_DONE;
                ans.position = POS_W'(slot);
            end
        end
        else if (r.operation == skset_pkg::OP_DELETE)
        begin
            if (hit)
            begin
                for (i = slot; i + 1 < shadow_count; i++)
                    shadow_keys[i] = shadow_keys[i+1];
                shadow_count--;
                ans.status = skset_pkg::ST_DONE;
                ans.position = POS_W'(slot);
            end
            else
                ans.status = skset_pkg::ST_ABSENT;
        end
        else
        begin
            // The spare operation code acts as a find, like the find code itself.
            if (hit)
            begin
                ans.status = skset_pkg::ST_DONE;
                ans.position = POS_W'(slot);
            end
            else
                ans.status = skset_pkg::ST_ABSENT;
        end
        ans.count = COUNT_W'(shadow_count);
        return ans;
    endfunction

    always @(posedge clk)
    begin
        skset_pkg::skset_rsp_t want;
        if (!rst_n)
        begin
            errors = 0;
            pending = 0;
            shadow_count = 0;
            expected_answers.delete();
        end
        else
        begin
            // The answer at this edge always belongs to an earlier word, so check first.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: answer with none expected:", $realtime,
                                 " status %0d position %0d count %0d",
                                 rsp.status, rsp.position, rsp.count);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp.status !== want.status || rsp.position !== want.position
                        || rsp.count !== want.count)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: expected status %0d position %0d count %0d,",
                                     $realtime, want.status, want.position, want.count,
                                     " got status %0d position %0d count %0d",
                                     rsp.status, rsp.position, rsp.count);
                    end
                end
            end
            if (req_valid && req_ready)
                expected_answers.push_back(apply_request(req));
            pending = expected_answers.size();
        end
    end

endmodule

FILE: verif/tb_sorted_key_set_top.sv
module tb_sorted_key_set_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                         CAPACITY    = skset_pkg::DEF_CAPACITY;
    localparam int                         KEY_BITS    = skset_pkg::DEF_KEY_BITS;
    localparam int                         OP_W        = skset_pkg::OP_W;
    localparam int                         KEY_W       = skset_pkg::KEY_W;
    localparam logic [OP_W-1:0]            OP_SPARE    = 2'd3;
    localparam int                         POOL_SIZE   = 320;
    localparam int                         CYCLE_LIMIT = 2_000_000;
    localparam int                         DRAIN_WAIT  = 300;
    localparam int                         HOLD_CYCLES = 3000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    skset_pkg::skset_req_t req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    skset_pkg::skset_rsp_t rsp;
    int                    errors;
    int                    pending;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    logic                  hold_go;
    logic                  rx_holding;
    int                    cycle_count = 0;

    sorted_key_set_top #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sorted_key_set_checker #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_sorted_key_set_top: done, errors");
            $finish;
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering words.
    initial
    begin
        rx_holding = 1'b0;
        wait (hold_go === 1'b1);
        rx_holding = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_holding = 1'b0;
    end

    // The receiver either sits out the long hold-off or stalls at random.
    always @(negedge clk)
    begin
        if (rx_holding)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Odd multiplier mod 2^16 spreads the pool indexes over distinct keys.
    function automatic logic [KEY_W-1:0] pool_key(int idx);
        return KEY_W'(idx * 40503 + 1234);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 70)
            return pool_key($urandom_range(0, POOL_SIZE - 1));
        return KEY_W'($urandom);
    endfunction

    // Offers one word after a random gap and returns at the edge that takes it.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= '{operation: op, key: key};
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic fill_store(int n);
        int base;
        base = $urandom_range(0, POOL_SIZE - 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(skset_pkg::OP_FIND, pick_key());
            send_word(skset_pkg::OP_INSERT, pool_key((base + i * 7) % POOL_SIZE));
        end
    endtask

    task automatic mixed_traffic(int n, int w_ins, int w_del);
        int roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < w_ins)
                send_word(skset_pkg::OP_INSERT, pick_key());
            else if (roll < w_ins + w_del)
                send_word(skset_pkg::OP_DELETE, pick_key());
            else if ($urandom_range(0, 4) == 0)
                send_word(OP_SPARE, pick_key());
            else
                send_word(skset_pkg::OP_FIND, pick_key());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        hold_go = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty set, ends of the key range, duplicates, absent keys, the spare code.
        send_word(skset_pkg::OP_FIND, 16'h1234);
        send_word(skset_pkg::OP_DELETE, 16'h1234);
        send_word(skset_pkg::OP_INSERT, 16'h8000);
        send_word(skset_pkg::OP_INSERT, 16'h0000);
        send_word(skset_pkg::OP_INSERT, 16'hFFFF);
        send_word(skset_pkg::OP_INSERT, 16'h4000);
        send_word(skset_pkg::OP_INSERT, 16'h0000);
        send_word(skset_pkg::OP_INSERT, 16'hFFFF);
        send_word(skset_pkg::OP_FIND, 16'h0000);
        send_word(skset_pkg::OP_FIND, 16'hFFFF);
        send_word(OP_SPARE, 16'h4000);
        send_word(OP_SPARE, 16'h4001);
        send_word(skset_pkg::OP_FIND, 16'h7FFF);
        send_word(skset_pkg::OP_DELETE, 16'h4001);
        send_word(skset_pkg::OP_DELETE, 16'h0000);
        send_word(skset_pkg::OP_DELETE, 16'hFFFF);
        send_word(skset_pkg::OP_DELETE, 16'h8000);
        send_word(skset_pkg::OP_DELETE, 16'h4000);
        send_word(skset_pkg::OP_INSERT, 16'hFFFF);
        send_word(skset_pkg::OP_FIND, 16'h5555);
        send_word(skset_pkg::OP_INSERT, 16'hAAAA);
        send_word(skset_pkg::OP_INSERT, 16'h5555);
        send_word(skset_pkg::OP_DELETE, 16'hAAAA);

        // Filling past capacity reaches the refused-insert case.
        fill_store(280);

        send_idle_pct = 71;
        mixed_traffic(180, 35, 35);

        send_idle_pct = 0;
        recv_stall_pct = 71;
        // Long receiver hold-off while words keep coming, so the input backs up.
        hold_go = 1'b1;
        mixed_traffic(200, 15, 65);

        send_idle_pct = 16;
        recv_stall_pct = 16;
        mixed_traffic(170, 40, 35);

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb_sorted_key_set_top: done, clean");
        else
            $display("tb_sorted_key_set_top: done, errors");
        $finish;
    end

endmodule

FILE: sorted_key_set_top.f
hdl/skset_pkg.sv
hdl/skset_ram.sv
hdl/sorted_key_set_top.sv
verif/sorted_key_set_checker.sv
verif/tb_sorted_key_set_top.sv
